/* src/ssh_cls_pkg.sv */
`default_nettype none
package ssh_cls_pkg;

	localparam int FLOW_ENTRIES_DEF = 16;
	localparam int MAX_FRAME_BYTES_DEF = 2048;

	localparam logic [6:0]  LINK_HDR_RST = 7'd14;
	localparam logic [10:0] MIN_FRAME_RST = 11'd54;

	localparam logic CFG_LINK_HDR = 1'b0;
	localparam logic CFG_MIN_FRAME = 1'b1;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int HDR_W = 8;

	localparam logic [7:0] TCP_FIN = 8'h01;
	localparam logic [7:0] TCP_RST = 8'h04;

	localparam int NFA_N = 77;
	localparam int HEAD_LAST = 7;
	localparam logic [7:0] DIGIT_MARK = 8'h23;

	localparam logic [7:0] NFA_CHARS [NFA_N] = '{
		8'h53, 8'h53, 8'h48, 8'h2D, 8'h23, 8'h2E, 8'h23, 8'h2D,
		8'h4F, 8'h70, 8'h65, 8'h6E, 8'h53, 8'h53, 8'h48, 8'h5F, 8'h23, 8'h2E, 8'h23,
		8'h41, 8'h50, 8'h41, 8'h43, 8'h48, 8'h45, 8'h2D, 8'h53, 8'h53, 8'h48, 8'h44,
		8'h2D, 8'h23, 8'h2E, 8'h23, 8'h2E, 8'h23,
		8'h46, 8'h69, 8'h6C, 8'h65, 8'h5A, 8'h69, 8'h6C, 8'h6C, 8'h61, 8'h5F, 8'h23,
		8'h2E, 8'h23, 8'h2E, 8'h23,
		8'h70, 8'h61, 8'h72, 8'h61, 8'h6D, 8'h69, 8'h6B, 8'h6F, 8'h5F, 8'h23, 8'h2E,
		8'h23, 8'h2E, 8'h23,
		8'h64, 8'h72, 8'h6F, 8'h70, 8'h62, 8'h65, 8'h61, 8'h72, 8'h5F, 8'h23, 8'h2E,
		8'h23
	};

	// first and last position of each product tag
	localparam logic [NFA_N-1:0] NFA_TAG_FIRST =
		(77'd1 << 8) | (77'd1 << 19) | (77'd1 << 36) | (77'd1 << 51) | (77'd1 << 65);
	localparam logic [NFA_N-1:0] NFA_TAG_LAST =
		(77'd1 << 18) | (77'd1 << 35) | (77'd1 << 50) | (77'd1 << 64) | (77'd1 << 76);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_t;

	typedef struct packed {
		logic is_ssh;
		logic table_full;
		logic short_frame;
	} out_t;

endpackage
`default_nettype wire

/* src/ssh_flow_banner_classifier_top.sv */
// result path: the frame summary register, then the output register, after the last frame byte is taken
// throughput: one byte per cycle, also across frame boundaries, unless the output stalls with a summary waiting
// the flow table is a compare-all array of flip-flops, updated once per frame end that is not short
// reset: configuration to defaults, frame state cleared, all flow entries invalid
`default_nettype none
module ssh_flow_banner_classifier_top #(
	parameter int FLOW_ENTRIES = ssh_cls_pkg::FLOW_ENTRIES_DEF,
	parameter int MAX_FRAME_BYTES = ssh_cls_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ssh_cls_pkg::in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ssh_cls_pkg::out_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [10:0]       cfg_data
);
	import ssh_cls_pkg::*;

	localparam int OW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int XW = (OW > 11) ? OW : 11;
	localparam logic [OW-1:0] MAX_POS = OW'(MAX_FRAME_BYTES);

	logic [6:0]  link_q;
	logic [10:0] min_q;

	logic [OW-1:0]     off_q, off_n;
	logic [ADDR_W-1:0] src_q, src_n, dst_q, dst_n;
	logic [PORT_W-1:0] sport_q, sport_n, dport_q, dport_n;
	logic [7:0]        flags_q, flags_n;
	logic [HDR_W-1:0]  pstart_q, pstart_n, tstart_q, tstart_n;
	logic              have_ip_q, have_ip_n, have_len_q, have_len_n;
	logic [NFA_N-1:0]  nfa_q, nfa_n, nfa_step;
	logic              match_q, match_n, term_q, term_n, nfa_hit;

	logic              in_acc, advance, s1_v_q;
	logic              short_s1, fr_s1, match_s1;
	logic [ADDR_W-1:0] src_s1, dst_s1;
	logic [PORT_W-1:0] sport_s1, dport_s1;

	logic [FLOW_ENTRIES-1:0] fv_q, hit_d, hit_s, hit_k, valid_r, free_v, free_1h;
	logic [ADDR_W-1:0]       fa_q [FLOW_ENTRIES];
	logic [PORT_W-1:0]       fp_q [FLOW_ENTRIES];
	logic                    do_ins;
	out_t                    res;
	out_t                    out_q;
	logic                    out_v_q;

	assign advance = !out_v_q || !out_stall;
	assign in_stall = s1_v_q && !advance;
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	// nfa next positions for the current byte
	always_comb begin
		logic dig, hit, pred;
		dig = (in_data.data_byte >= 8'h30) && (in_data.data_byte <= 8'h39);
		nfa_step = '0;
		nfa_hit = 1'b0;
		hit = (in_data.data_byte == NFA_CHARS[0]);
		nfa_step[0] = hit;
		for (int i = 1; i < NFA_N; i++) begin
			hit = (NFA_CHARS[i] == DIGIT_MARK) ? dig : (in_data.data_byte == NFA_CHARS[i]);
			pred = NFA_TAG_FIRST[i] ? nfa_q[HEAD_LAST] : nfa_q[i-1];
			nfa_step[i] = hit && (pred || ((NFA_CHARS[i] == DIGIT_MARK) && nfa_q[i]));
			if (nfa_step[i] && NFA_TAG_LAST[i]) begin
				nfa_hit = 1'b1;
			end
		end
	end

	// header capture and scan control
	always_comb begin
		logic          in_range, at_ip, scan;
		logic [OW-1:0] ip_rel;
		logic [XW-1:0] t;
		logic [7:0]    b;
		b = in_data.data_byte;
		in_range = off_q < MAX_POS;
		at_ip = (off_q == OW'(link_q));
		src_n = src_q;
		dst_n = dst_q;
		sport_n = sport_q;
		dport_n = dport_q;
		flags_n = flags_q;
		pstart_n = pstart_q;
		tstart_n = tstart_q;
		have_ip_n = have_ip_q;
		have_len_n = have_len_q;
		off_n = off_q;
		nfa_n = nfa_q;
		match_n = match_q;
		term_n = term_q;
		ip_rel = off_q - OW'(link_q);
		t = '0;
		if (in_range) begin
			if (at_ip) begin
				tstart_n = HDR_W'(link_q) + HDR_W'({b[3:0], 2'b00});
				have_ip_n = 1'b1;
			end
			if (have_ip_n) begin
				if (ip_rel >= OW'(12) && ip_rel <= OW'(15)) begin
					src_n = {src_q[ADDR_W-9:0], b};
				end else if (ip_rel >= OW'(16) && ip_rel <= OW'(19)) begin
					dst_n = {dst_q[ADDR_W-9:0], b};
				end
				if (XW'(off_q) >= XW'(tstart_n)) begin
					t = XW'(off_q) - XW'(tstart_n);
					if (t <= XW'(1)) begin
						sport_n = {sport_q[7:0], b};
					end else if (t <= XW'(3)) begin
						dport_n = {dport_q[7:0], b};
					end else if (t == XW'(12)) begin
						pstart_n = tstart_n + HDR_W'({b[7:4], 2'b00});
						have_len_n = 1'b1;
					end else if (t == XW'(13)) begin
						flags_n = b;
					end
				end
			end
			off_n = off_q + OW'(1);
		end
		scan = have_len_n && !term_q && !match_q &&
			(!in_range || XW'(off_q) >= XW'(pstart_n));
		if (scan) begin
			if (b == 8'h00) begin
				term_n = 1'b1;
			end else begin
				nfa_n = nfa_step;
				match_n = nfa_hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= LINK_HDR_RST;
			min_q <= MIN_FRAME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINK_HDR:  link_q <= cfg_data[6:0];
				CFG_MIN_FRAME: min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
			flags_q <= '0;
			pstart_q <= '0;
			tstart_q <= '0;
			have_ip_q <= 1'b0;
			have_len_q <= 1'b0;
			nfa_q <= '0;
			match_q <= 1'b0;
			term_q <= 1'b0;
		end else if (in_acc) begin
			if (in_data.end_of_frame) begin
				off_q <= '0;
				src_q <= '0;
				dst_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
				flags_q <= '0;
				pstart_q <= '0;
				tstart_q <= '0;
				have_ip_q <= 1'b0;
				have_len_q <= 1'b0;
				nfa_q <= '0;
				match_q <= 1'b0;
				term_q <= 1'b0;
			end else begin
				off_q <= off_n;
				src_q <= src_n;
				dst_q <= dst_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
				flags_q <= flags_n;
				pstart_q <= pstart_n;
				tstart_q <= tstart_n;
				have_ip_q <= have_ip_n;
				have_len_q <= have_len_n;
				nfa_q <= nfa_n;
				match_q <= match_n;
				term_q <= term_n;
			end
		end
	end

	// frame summary at the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else begin
			s1_v_q <= (in_acc && in_data.end_of_frame) || (s1_v_q && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.end_of_frame) begin
			short_s1 <= XW'(off_n) < XW'(min_q);
			fr_s1 <= ((flags_n & TCP_FIN) != 8'h00) || ((flags_n & TCP_RST) != 8'h00);
			match_s1 <= match_n;
			src_s1 <= src_n;
			dst_s1 <= dst_n;
			sport_s1 <= sport_n;
			dport_s1 <= dport_n;
		end
	end

	// flow table lookup, removal and insert
	always_comb begin
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			hit_d[i] = fv_q[i] && fa_q[i] == dst_s1 && fp_q[i] == dport_s1;
			hit_s[i] = fv_q[i] && fa_q[i] == src_s1 && fp_q[i] == sport_s1;
		end
		valid_r = fr_s1 ? (fv_q & ~(hit_d | hit_s)) : fv_q;
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			hit_k[i] = valid_r[i] && fa_q[i] == src_s1 && fp_q[i] == dport_s1;
		end
		free_v = ~valid_r;
		free_1h = free_v & (~free_v + FLOW_ENTRIES'(1));
		do_ins = match_s1 && !(|hit_k) && (|free_v);
		res.short_frame = short_s1;
		res.is_ssh = !short_s1 && (match_s1 || (|hit_k));
		res.table_full = !short_s1 && match_s1 && !(|hit_k) && !(|free_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
		end else if (s1_v_q && advance && !short_s1) begin
			fv_q <= do_ins ? (valid_r | free_1h) : valid_r;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			if (s1_v_q && advance && !short_s1 && do_ins && free_1h[i]) begin
				fa_q[i] <= src_s1;
				fp_q[i] <= dport_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_v_q) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_short_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.short_frame |-> !out_data.is_ssh && !out_data.table_full)
		else $error("short frame with flow result");
	a_full_is_ssh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |-> out_data.is_ssh)
		else $error("table full without match");
	a_hold_summary: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !advance |-> in_stall)
		else $error("input taken while frame summary blocked");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && advance |=> out_valid)
		else $error("frame summary lost");
`endif

endmodule
`default_nettype wire

/* test/ssh_flow_banner_classifier_top_tb.sv */
`default_nettype none
module ssh_flow_banner_classifier_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssh_cls_pkg::*;

	localparam int TBL_N = FLOW_ENTRIES_DEF;
	localparam int FRAME_MAX = MAX_FRAME_BYTES_DEF;

	class flow_scoreboard;
		int link_hdr, min_frame;
		int offset, tcp_start, pay_start;
		bit have_ip, have_tcp_len, matched, terminated;
		bit [31:0] src_addr, dst_addr;
		bit [15:0] src_port, dst_port;
		bit [7:0] flags;
		bit [127:0] nfa_pos;
		bit fvalid [TBL_N];
		bit [31:0] faddr [TBL_N];
		bit [15:0] fport [TBL_N];
		out_t expected_q[$];
		int errors;
		int seg_base [6];
		int seg_len [6];

		function void clear_frame();
			offset = 0; tcp_start = 0; pay_start = 0;
			have_ip = 0; have_tcp_len = 0; matched = 0; terminated = 0;
			src_addr = 0; dst_addr = 0; src_port = 0; dst_port = 0; flags = 0;
			nfa_pos = '0;
		endfunction

		function void reset_all();
			seg_base = '{0, 8, 19, 36, 51, 65};
			seg_len = '{8, 11, 17, 15, 14, 12};
			link_hdr = LINK_HDR_RST;
			min_frame = MIN_FRAME_RST;
			clear_frame();
			for (int i = 0; i < TBL_N; i++) fvalid[i] = 0;
			errors = 0;
		endfunction

		function void set_reg(logic idx, bit [10:0] v);
			if (idx == CFG_LINK_HDR) link_hdr = v[6:0];
			else min_frame = v;
		endfunction

		function void nfa_step(bit [7:0] c);
			bit [127:0] nxt;
			bit digit, hit, pred, self_loop;
			int idx;
			bit [7:0] e;
			nxt = '0;
			digit = (c >= 8'h30 && c <= 8'h39);
			for (int s = 0; s < 6; s++) begin
				for (int k = 0; k < seg_len[s]; k++) begin
					idx = seg_base[s] + k;
					e = NFA_CHARS[idx];
					hit = (e == DIGIT_MARK) ? digit : (e == c);
					if (hit) begin
						if (k == 0) pred = (s == 0) ? 1'b1 : nfa_pos[HEAD_LAST];
						else pred = nfa_pos[idx-1];
						self_loop = (e == DIGIT_MARK) && nfa_pos[idx];
						if (pred || self_loop) begin
							nxt[idx] = 1'b1;
							if (s > 0 && k + 1 == seg_len[s]) matched = 1;
						end
					end
				end
			end
			nfa_pos = nxt;
		endfunction

		function int flow_find(bit [31:0] a, bit [15:0] p);
			for (int i = 0; i < TBL_N; i++)
				if (fvalid[i] && faddr[i] == a && fport[i] == p) return i;
			return -1;
		endfunction

		function void note_byte(in_t d);
			int pos, ip_rel, t, hit_idx;
			bit in_range, placed;
			bit [7:0] b;
			out_t r;
			b = d.data_byte;
			pos = offset;
			in_range = pos < FRAME_MAX;
			if (in_range) begin
				if (pos == link_hdr) begin
					tcp_start = link_hdr + int'(b[3:0]) * 4;
					have_ip = 1;
				end
				if (have_ip) begin
					ip_rel = pos - link_hdr;
					if (ip_rel >= 12 && ip_rel <= 15) src_addr = {src_addr[23:0], b};
					else if (ip_rel >= 16 && ip_rel <= 19) dst_addr = {dst_addr[23:0], b};
					if (pos >= tcp_start) begin
						t = pos - tcp_start;
						if (t <= 1) src_port = {src_port[7:0], b};
						else if (t <= 3) dst_port = {dst_port[7:0], b};
						else if (t == 12) begin
							pay_start = tcp_start + int'(b[7:4]) * 4;
							have_tcp_len = 1;
						end else if (t == 13) flags = b;
					end
				end
				offset = pos + 1;
			end
			if (have_tcp_len && !terminated && !matched && (!in_range || pos >= pay_start)) begin
				if (b == 8'h00) terminated = 1;
				else nfa_step(b);
			end
			if (!d.end_of_frame) return;
			r = '0;
			if (offset < min_frame) begin
				r.short_frame = 1'b1;
			end else begin
				if ((flags & TCP_FIN) != 0 || (flags & TCP_RST) != 0) begin
					hit_idx = flow_find(dst_addr, dst_port);
					if (hit_idx >= 0) fvalid[hit_idx] = 0;
					hit_idx = flow_find(src_addr, src_port);
					if (hit_idx >= 0) fvalid[hit_idx] = 0;
				end
				if (matched) begin
					r.is_ssh = 1'b1;
					if (flow_find(src_addr, dst_port) < 0) begin
						placed = 0;
						for (int i = 0; i < TBL_N && !placed; i++) begin
							if (!fvalid[i]) begin
								fvalid[i] = 1; faddr[i] = src_addr; fport[i] = dst_port;
								placed = 1;
							end
						end
						if (!placed) r.table_full = 1'b1;
					end
				end else if (flow_find(src_addr, dst_port) >= 0) begin
					r.is_ssh = 1'b1;
				end
			end
			expected_q.push_back(r);
			clear_frame();
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %b", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.is_ssh !== want.is_ssh) begin
				$display("%0t is_ssh: expected %b actual %b", $time, want.is_ssh, got.is_ssh);
				errors++;
			end
			if (got.table_full !== want.table_full) begin
				$display("%0t table_full: expected %b actual %b", $time, want.table_full,
					got.table_full);
				errors++;
			end
			if (got.short_frame !== want.short_frame) begin
				$display("%0t short_frame: expected %b actual %b", $time, want.short_frame,
					got.short_frame);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall, cfg_we;
	in_t in_data;
	out_t out_data;
	logic cfg_index;
	logic [10:0] cfg_data;

	ssh_flow_banner_classifier_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	flow_scoreboard sb;
	bit [7:0] frame_q[$];
	int sent_bytes, sent_frames, stall_pct, hold_req;
	bit [31:0] addr_pool [4] = '{32'hC0A80001, 32'h0A000002, 32'hFFFFFFFF, 32'h00000000};
	bit [15:0] port_pool [6] = '{16'd22, 16'd2222, 16'hFFFF, 16'h0000, 16'd443, 16'd8022};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		int hold;
		out_stall = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 199) == 0) begin
				hold = $urandom_range(20, 60);
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 99) == 0) stall_pct = $urandom_range(0, 3) * 20;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic put_at(int pos, bit [7:0] v);
		while (frame_q.size() <= pos) frame_q.push_back(8'($urandom_range(1, 255)));
		frame_q[pos] = v;
	endtask

	task automatic put_banner(int pos);
		int s, bases [6], lens [6], p, n;
		bit [7:0] c;
		bases = '{0, 8, 19, 36, 51, 65};
		lens = '{8, 11, 17, 15, 14, 12};
		s = $urandom_range(1, 5);
		p = pos;
		for (int part = 0; part < 2; part++) begin
			for (int k = 0; k < lens[part == 0 ? 0 : s]; k++) begin
				c = NFA_CHARS[bases[part == 0 ? 0 : s] + k];
				if (c == DIGIT_MARK) begin
					n = $urandom_range(1, 3);
					repeat (n) begin
						put_at(p, 8'(8'h30 + $urandom_range(0, 9)));
						p++;
					end
				end else begin
					if ($urandom_range(0, 99) == 0) c = c ^ 8'h01;
					put_at(p, c);
					p++;
				end
			end
		end
		if ($urandom_range(0, 3) == 0) put_at(p, 8'h00);
	endtask

	task automatic build_frame(int len_kind);
		int lh, ihl, ts, doff, ps, len;
		bit [31:0] sa, da;
		bit [15:0] sp, dp;
		bit [7:0] fl;
		frame_q.delete();
		lh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : sb.link_hdr;
		ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
		for (int i = 0; i < lh; i++) frame_q.push_back(8'($urandom_range(0, 255)));
		put_at(lh, {4'h4, 4'(ihl)});
		sa = addr_pool[$urandom_range(0, 3)];
		da = addr_pool[$urandom_range(0, 3)];
		if ($urandom_range(0, 3) == 0) sa = $urandom;
		for (int i = 0; i < 4; i++) begin
			put_at(lh + 12 + i, sa[31-8*i -: 8]);
			put_at(lh + 16 + i, da[31-8*i -: 8]);
		end
		ts = lh + ihl * 4;
		sp = port_pool[$urandom_range(0, 5)];
		dp = port_pool[$urandom_range(0, 5)];
		if ($urandom_range(0, 3) == 0) dp = 16'($urandom);
		put_at(ts, sp[15:8]); put_at(ts + 1, sp[7:0]);
		put_at(ts + 2, dp[15:8]); put_at(ts + 3, dp[7:0]);
		doff = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
		put_at(ts + 12, {4'(doff), 4'($urandom_range(0, 15))});
		case ($urandom_range(0, 5))
			0: fl = TCP_FIN | 8'h10;
			1: fl = TCP_RST;
			2: fl = 8'($urandom_range(0, 255));
			default: fl = 8'($urandom_range(0, 255)) & ~(TCP_FIN | TCP_RST);
		endcase
		put_at(ts + 13, fl);
		ps = ts + doff * 4;
		while (frame_q.size() < ps) frame_q.push_back(8'($urandom_range(0, 255)));
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
				put_banner(frame_q.size());
			end
			3: repeat ($urandom_range(0, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
			4: repeat ($urandom_range(0, 30)) frame_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'h53);
			default: ;
		endcase
		if (len_kind == 1) begin
			len = $urandom_range(1, frame_q.size());
			while (frame_q.size() > len) void'(frame_q.pop_back());
		end else if (len_kind == 2) begin
			while (frame_q.size() < FRAME_MAX + 60) frame_q.push_back(8'($urandom_range(1, 255)));
			put_banner(frame_q.size());
		end
	endtask

	task automatic send_byte(bit [7:0] b, bit last, bit no_gaps);
		in_t d;
		int r;
		d.data_byte = b;
		d.end_of_frame = last;
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (in_stall);
		sb.note_byte(d);
		sent_bytes++;
		if (last) sent_frames++;
		r = $urandom_range(0, 99);
		if (!no_gaps && r >= 60) begin
			in_valid <= 1'b0;
			repeat (r < 97 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
		end
	endtask

	task automatic send_frame(int len_kind);
		bit no_gaps;
		build_frame(len_kind);
		no_gaps = ($urandom_range(0, 3) == 0);
		foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, no_gaps);
	endtask

	task automatic write_reg(logic idx, bit [10:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int links [6] = '{14, 0, 64, 64, 3, 14};
		int mins [6] = '{54, 0, 2047, 100, 20, 54};
		sb = new;
		sb.reset_all();
		stall_pct = 20;
		hold_req = 0;
		sent_bytes = 0;
		sent_frames = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = CFG_LINK_HDR;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, banners, short frames, single-byte frames
		for (int i = 0; i < 6; i++) send_frame(0);
		send_frame(1);
		write_reg(CFG_MIN_FRAME, 11'd0);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hA5, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b1, 1'b0);

		// receiver holds off while tiny frames keep coming
		hold_req = 1;
		for (int i = 0; i < 60; i++)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		send_byte(8'h01, 1'b1, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_LINK_HDR, 11'(links[ph]));
			write_reg(CFG_MIN_FRAME, 11'(mins[ph]));
			sent_bytes = 0;
			sent_frames = 0;
			while (sent_bytes < 150 || sent_frames < 2) begin
				case ($urandom_range(0, 19))
					0, 1, 2: send_frame(1);
					default: send_frame(0);
				endcase
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
